FILE: hw/rtl/sast_pkg.sv
package sast_pkg;

    localparam int MAX_SPACES_DEF    = 16;
    localparam int MAX_FRAGMENTS_DEF = 64;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam int REQ_W   = 3;
    localparam int SPACE_W = 4;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_EXTEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_L2G    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_G2L    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SIZE   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [SPACE_W-1:0] space_id;
        logic [DATA_W-1:0]  amount;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SPACE_W-1:0] space_out;
        logic [DATA_W-1:0]  address_out;
        logic [DATA_W-1:0]  global_size;
    } t_rsp;

endpackage

FILE: hw/rtl/sast_ram.sv
module sast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/segmented_address_space_translator.sv
// channel | direction | handshake            | payload
// request | in        | i_req_valid/o_req_ready | i_req (t_req)
// result  | out       | o_rsp_valid/i_rsp_ready | o_rsp (t_rsp)
// an item passes through accept, memory read and execute, except a translation, which
// walks the fragment memory one entry per cycle through its read port until a hit
// or the last fragment
// reset clears counts and totals; size and fragment memories are not cleared
// a new item is taken while the previous result still waits in the output register;
// execution then stalls until that result is taken
module segmented_address_space_translator
    import sast_pkg::*;
#(
    parameter int MAX_SPACES    = MAX_SPACES_DEF,
    parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int SA_W = $clog2(MAX_SPACES);
    localparam int SC_W = $clog2(MAX_SPACES + 1);
    localparam int FA_W = $clog2(MAX_FRAGMENTS);
    localparam int FC_W = $clog2(MAX_FRAGMENTS + 1);
    localparam int OB   = OFFSET_BITS;
    localparam int FR_W = SA_W + 3 * OB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          r_state;
    t_req                r_req;
    logic [SC_W-1:0]     r_space_count;
    logic [OB-1:0]       r_global_total;
    logic [FC_W-1:0]     r_frag_count;
    logic [FC_W-1:0]     r_idx;
    logic                r_out_valid;
    t_rsp                r_out;

    logic                sz_we;
    logic [SA_W-1:0]     sz_waddr, sz_raddr;
    logic [OB-1:0]       sz_wdata, sz_rdata;
    logic                fr_we;
    logic [FA_W-1:0]     fr_waddr, fr_raddr;
    logic [FR_W-1:0]     fr_wdata, fr_rdata;

    logic [SA_W-1:0]     f_space;
    logic [OB-1:0]       f_lstart, f_size, f_gstart;
    logic [OB-1:0]       amt;
    logic                amt_big;
    logic [SA_W-1:0]     sid;
    logic                sid_ok;
    logic [OB:0]         ext_sum;
    logic                hit;
    logic [OB-1:0]       delta;
    logic                out_free;
    logic                walk_go;
    logic                out_set;

    sast_ram #(.WIDTH(OB), .DEPTH(MAX_SPACES)) u_sizes (
        .i_clk(i_clk), .i_we(sz_we), .i_waddr(sz_waddr), .i_wdata(sz_wdata),
        .i_raddr(sz_raddr), .o_rdata(sz_rdata)
    );

    sast_ram #(.WIDTH(FR_W), .DEPTH(MAX_FRAGMENTS)) u_frags (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );

    assign {f_space, f_lstart, f_size, f_gstart} = fr_rdata;

    assign amt      = OB'(r_req.amount);
    assign amt_big  = (r_req.amount >> OB) != '0;
    assign sid      = SA_W'(r_req.space_id);
    assign sid_ok   = ({{(DATA_W-SPACE_W){1'b0}}, r_req.space_id} <
                       DATA_W'(r_space_count));
    assign ext_sum  = {1'b0, r_global_total} + {1'b0, amt};
    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        if (r_req.req_type == REQ_L2G) begin
            delta = amt - f_lstart;
            hit   = (f_space == sid) && (amt >= f_lstart) && (delta < f_size);
        end else begin
            delta = amt - f_gstart;
            hit   = (amt >= f_gstart) && (delta < f_size);
        end
    end

    always_comb begin
        walk_go = 1'b0;
        if (r_req.req_type == REQ_L2G) begin
            walk_go = sid_ok && !amt_big && (amt < sz_rdata) && (r_frag_count != '0);
        end else if (r_req.req_type == REQ_G2L) begin
            walk_go = !amt_big && (amt < r_global_total) && (r_frag_count != '0);
        end
    end

    assign out_set = out_free && ((r_state == S_EXEC && !walk_go) || r_state == S_DONE);

    assign sz_raddr    = (r_state == S_IDLE) ? SA_W'(i_req.space_id) : sid;
    assign sz_waddr    = (r_req.req_type == REQ_ALLOC) ? r_space_count[SA_W-1:0] : sid;
    assign sz_wdata    = (r_req.req_type == REQ_ALLOC) ? '0 : sz_rdata + amt;
    assign fr_raddr    = r_idx[FA_W-1:0];
    assign fr_waddr    = r_frag_count[FA_W-1:0];
    assign fr_wdata    = {sid, sz_rdata, amt, r_global_total};
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    function automatic t_rsp mk(input logic [STAT_W-1:0] st, input logic [SPACE_W-1:0] sp,
                                input logic [OB-1:0] ad, input logic [OB-1:0] gt);
        t_rsp r;
        r.status      = st;
        r.space_out   = sp;
        r.address_out = DATA_W'(ad);
        r.global_size = DATA_W'(gt);
        return r;
    endfunction

    always_comb begin
        sz_we = 1'b0;
        fr_we = 1'b0;
        if (r_state == S_EXEC && out_free) begin
            if (r_req.req_type == REQ_ALLOC) begin
                sz_we = (r_space_count < SC_W'(MAX_SPACES));
            end else if (r_req.req_type == REQ_EXTEND && sid_ok && !ext_sum[OB] &&
                         !amt_big && amt != '0 &&
                         r_frag_count < FC_W'(MAX_FRAGMENTS)) begin
                sz_we = 1'b1;
                fr_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_set) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_space_count  <= '0;
            r_global_total <= '0;
            r_frag_count   <= '0;
            r_idx          <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= walk_go ? S_WALK : S_IDLE;
                        unique case (r_req.req_type)
                            REQ_ALLOC: begin
                                if (r_space_count >= SC_W'(MAX_SPACES)) begin
                                    r_out <= mk(ST_FULL, '0, '0, r_global_total);
                                end else begin
                                    r_space_count <= r_space_count + 1'b1;
                                    r_out <= mk(ST_OK, SPACE_W'(r_space_count), '0,
                                                r_global_total);
                                end
                            end
                            REQ_EXTEND: begin
                                if (!sid_ok) begin
                                    r_out <= mk(ST_INVALID, '0, '0, r_global_total);
                                end else if (ext_sum[OB] || amt_big) begin
                                    r_out <= mk(ST_RANGE, '0, '0, r_global_total);
                                end else if (amt == '0) begin
                                    r_out <= mk(ST_OK, '0, r_global_total, r_global_total);
                                end else if (r_frag_count >= FC_W'(MAX_FRAGMENTS)) begin
                                    r_out <= mk(ST_FULL, '0, '0, r_global_total);
                                end else begin
                                    r_frag_count   <= r_frag_count + 1'b1;
                                    r_global_total <= ext_sum[OB-1:0];
                                    r_out <= mk(ST_OK, '0, r_global_total, ext_sum[OB-1:0]);
                                end
                            end
                            REQ_L2G, REQ_G2L: begin
                                if (walk_go) begin
                                    r_idx <= r_idx + 1'b1;
                                end else if (r_req.req_type == REQ_L2G && !sid_ok) begin
                                    r_out <= mk(ST_INVALID, '0, '0, r_global_total);
                                end else begin
                                    r_out <= mk(ST_RANGE, '0, '0, r_global_total);
                                end
                            end
                            REQ_SIZE: begin
                                if (!sid_ok) begin
                                    r_out <= mk(ST_INVALID, '0, '0, r_global_total);
                                end else begin
                                    r_out <= mk(ST_OK, '0, sz_rdata, r_global_total);
                                end
                            end
                            default: begin
                                r_out <= mk(ST_OK, '0, '0, r_global_total);
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (hit || r_idx >= r_frag_count) begin
                        r_state <= S_DONE;
                        if (hit) begin
                            r_out <= mk(ST_OK,
                                        (r_req.req_type == REQ_G2L) ? SPACE_W'(f_space) : '0,
                                        (r_req.req_type == REQ_G2L) ? f_lstart + delta
                                                                    : f_gstart + delta,
                                        r_global_total);
                        end else begin
                            r_out <= mk(ST_RANGE, '0, '0, r_global_total);
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_space_count <= SC_W'(MAX_SPACES))
        else $error("space count above limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frag_count <= FC_W'(MAX_FRAGMENTS))
        else $error("fragment count above limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_req_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frag_count == '0) |-> (r_global_total == '0))
        else $error("global size without fragments");

endmodule
